/* rtl/stad_pkg.sv */
`timescale 1ns / 1ps

package stad_pkg;

    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [9:0] slot;
        logic [1:0] access_type;
        logic [7:0] data_byte;
    } t_in;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_REPEAT = 2'd1,
        ERR_ORDER  = 2'd2
    } t_err;

    typedef struct packed {
        logic [63:0] address;
        logic [9:0]  out_slot;
        logic [1:0]  out_type;
        t_err        error;
    } t_out;

    typedef struct packed {
        logic [63:0] addr;
        logic [63:0] stride;
        logic [63:0] rep;
    } t_entry;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_OFFSET = 3'd2,
        PH_STRIDE = 3'd3,
        PH_REPEAT = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        B_CLEAR = 3'd0,
        B_IDLE  = 3'd1,
        B_LOOK  = 3'd2,
        B_SUM   = 3'd3,
        B_FIN   = 3'd4
    } t_bstate;

    typedef struct packed {
        logic clearing;
    } t_bstat;

    function automatic logic [3:0] size_bytes(input logic [1:0] code);
        logic [3:0] n;
        unique case (code)
            2'd0: n = 4'd1;
            2'd1: n = 4'd2;
            2'd2: n = 4'd4;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

/* rtl/stad_queue.sv */
`timescale 1ns / 1ps

module stad_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/stad_front.sv */
`timescale 1ns / 1ps

module stad_front #(
    parameter int SLOT_COUNT = stad_pkg::SLOT_COUNT_DEF,
    parameter int IW         = $clog2(SLOT_COUNT)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  stad_pkg::t_in   i_item,
    input  stad_pkg::t_bstat i_stat,
    input  logic            i_full,
    output logic            o_push,
    output stad_pkg::t_in   o_item,
    output logic [IW-1:0]   o_idx
);
    localparam logic [16:0] MUL = 17'((1 << 20) / SLOT_COUNT);

    logic          r_v;
    stad_pkg::t_in r_item;
    logic [9:0]    r_q;
    logic [29:0]   prod;
    logic [26:0]   qc, rem, rem2;

    assign prod    = 30'(i_item.slot) * 30'(MUL);
    assign o_ready = !i_stat.clearing && (!r_v || !i_full);
    assign o_push  = r_v && !i_full;
    assign o_item  = r_item;

    // slot modulo slot count: reciprocal quotient, then one correction
    always_comb begin
        qc   = 27'(r_q) * 27'(SLOT_COUNT);
        rem  = 27'(r_item.slot) - qc;
        rem2 = (rem >= 27'(SLOT_COUNT)) ? rem - 27'(SLOT_COUNT) : rem;
    end
    assign o_idx = rem2[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
            r_q    <= prod[29:20];
        end
    end

endmodule

/* rtl/stad_back.sv */
`timescale 1ns / 1ps

module stad_back #(
    parameter int SLOT_COUNT = stad_pkg::SLOT_COUNT_DEF,
    parameter int IW         = $clog2(SLOT_COUNT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  stad_pkg::t_in    i_head,
    input  logic [IW-1:0]    i_head_idx,
    output logic             o_pop,
    output stad_pkg::t_bstat o_stat,
    output logic             o_valid,
    input  logic             i_ready,
    output stad_pkg::t_out   o_item
);
    stad_pkg::t_entry  r_mem [SLOT_COUNT];
    stad_pkg::t_entry  r_rd, wd;
    logic [IW-1:0]     ra, wa;
    logic              we;

    stad_pkg::t_bstate r_state, n_state;
    stad_pkg::t_phase  r_phase, n_phase;
    logic [IW-1:0]     r_clr, n_clr, r_cidx, n_cidx;
    logic [9:0]        r_cslot, n_cslot;
    logic [1:0]        r_ctype, n_ctype;
    logic [7:0]        r_hdr, n_hdr;
    logic [63:0]       r_acc, n_acc, r_off, n_off, r_str, n_str, r_rep, n_rep;
    logic [63:0]       r_base, n_base, r_a, n_a;
    logic [3:0]        r_left, n_left;

    logic              r_ov;
    stad_pkg::t_out    r_out, emit_val;
    logic              emit, out_free, go_rep, done;
    logic [1:0]        fsel;
    logic [3:0]        total;
    logic [2:0]        bidx, sc, rc;
    logic [63:0]       acc, v;

    assign out_free        = !r_ov || i_ready;
    assign o_valid         = r_ov;
    assign o_item          = r_out;
    assign o_stat.clearing = (r_state == stad_pkg::B_CLEAR);
    assign ra              = (r_state == stad_pkg::B_LOOK) ? r_cidx : i_head_idx;

    // field byte assembly
    always_comb begin
        sc = r_hdr[4:2];
        rc = r_hdr[7:5];
        unique case (r_phase)
            stad_pkg::PH_OFFSET: fsel = r_hdr[1:0];
            stad_pkg::PH_STRIDE: fsel = 2'(sc - 3'd1);
            default:             fsel = 2'(rc - 3'd1);
        endcase
        total = stad_pkg::size_bytes(fsel);
        bidx  = 3'(total - r_left);
        acc   = r_acc | (64'(i_head.data_byte) << {bidx, 3'b000});
        done  = (r_left == 4'd1) || ({1'b0, bidx} + 4'd1 >= total);
        unique case (fsel)
            2'd0: v = {{56{acc[7]}}, acc[7:0]};
            2'd1: v = {{48{acc[15]}}, acc[15:0]};
            2'd2: v = {{32{acc[31]}}, acc[31:0]};
            default: v = acc;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_clr    = r_clr;
        n_cidx   = r_cidx;
        n_cslot  = r_cslot;
        n_ctype  = r_ctype;
        n_hdr    = r_hdr;
        n_acc    = r_acc;
        n_off    = r_off;
        n_str    = r_str;
        n_rep    = r_rep;
        n_base   = r_base;
        n_a      = r_a;
        n_left   = r_left;
        o_pop    = 1'b0;
        emit     = 1'b0;
        emit_val = '0;
        we       = 1'b0;
        wa       = r_cidx;
        wd       = '0;
        go_rep   = 1'b0;

        unique case (r_state)
            stad_pkg::B_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == IW'(SLOT_COUNT-1)) begin
                    n_state = stad_pkg::B_IDLE;
                end
            end
            stad_pkg::B_IDLE: begin
                if (!i_empty) begin
                    if (i_head.kind == stad_pkg::KIND_REQ) begin
                        if (r_phase != stad_pkg::PH_IDLE) begin
                            if (out_free) begin
                                o_pop             = 1'b1;
                                emit              = 1'b1;
                                emit_val.out_slot = i_head.slot;
                                emit_val.out_type = i_head.access_type;
                                emit_val.error    = stad_pkg::ERR_ORDER;
                            end
                        end else begin
                            o_pop   = 1'b1;
                            n_cidx  = i_head_idx;
                            n_cslot = i_head.slot;
                            n_ctype = i_head.access_type;
                            n_state = stad_pkg::B_LOOK;
                        end
                    end else begin
                        unique case (r_phase)
                            stad_pkg::PH_IDLE: begin
                                if (out_free) begin
                                    o_pop          = 1'b1;
                                    emit           = 1'b1;
                                    emit_val.error = stad_pkg::ERR_ORDER;
                                end
                            end
                            stad_pkg::PH_HEADER: begin
                                if (i_head.data_byte[7:6] == 2'b11) begin
                                    if (out_free) begin
                                        o_pop             = 1'b1;
                                        emit              = 1'b1;
                                        emit_val.out_slot = r_cslot;
                                        emit_val.out_type = r_ctype;
                                        emit_val.error    = stad_pkg::ERR_REPEAT;
                                        n_hdr             = i_head.data_byte;
                                        n_phase           = stad_pkg::PH_IDLE;
                                    end
                                end else begin
                                    o_pop   = 1'b1;
                                    n_hdr   = i_head.data_byte;
                                    n_phase = stad_pkg::PH_OFFSET;
                                    n_left  = stad_pkg::size_bytes(i_head.data_byte[1:0]);
                                    n_acc   = '0;
                                end
                            end
                            default: begin
                                o_pop  = 1'b1;
                                n_acc  = acc;
                                n_left = r_left - 4'd1;
                                if (done) begin
                                    unique case (r_phase)
                                        stad_pkg::PH_OFFSET: begin
                                            n_off = v;
                                            case (sc)
                                                3'd0: begin n_str = 64'd0; go_rep = 1'b1; end
                                                3'd5: begin n_str = 64'd1; go_rep = 1'b1; end
                                                3'd6: begin n_str = 64'd4; go_rep = 1'b1; end
                                                3'd7: begin n_str = 64'd8; go_rep = 1'b1; end
                                                default: begin
                                                    n_phase = stad_pkg::PH_STRIDE;
                                                    n_left  = stad_pkg::size_bytes(2'(sc - 3'd1));
                                                    n_acc   = '0;
                                                end
                                            endcase
                                        end
                                        stad_pkg::PH_STRIDE: begin
                                            n_str  = v;
                                            go_rep = 1'b1;
                                        end
                                        default: begin
                                            n_rep   = v;
                                            n_state = stad_pkg::B_SUM;
                                        end
                                    endcase
                                    if (go_rep) begin
                                        case (rc)
                                            3'd0: begin
                                                n_rep   = 64'd0;
                                                n_state = stad_pkg::B_SUM;
                                            end
                                            3'd5: begin
                                                n_rep   = 64'd1;
                                                n_state = stad_pkg::B_SUM;
                                            end
                                            default: begin
                                                n_phase = stad_pkg::PH_REPEAT;
                                                n_left  = stad_pkg::size_bytes(2'(rc - 3'd1));
                                                n_acc   = '0;
                                            end
                                        endcase
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            stad_pkg::B_LOOK: begin
                if (r_rd.rep != 64'd0) begin
                    if (out_free) begin
                        emit              = 1'b1;
                        emit_val.address  = r_rd.addr;
                        emit_val.out_slot = r_cslot;
                        emit_val.out_type = r_ctype;
                        emit_val.error    = stad_pkg::ERR_OK;
                        we                = 1'b1;
                        wd.addr           = r_rd.addr + r_rd.stride;
                        wd.stride         = r_rd.stride;
                        wd.rep            = r_rd.rep - 64'd1;
                        n_state           = stad_pkg::B_IDLE;
                    end
                end else begin
                    n_base  = r_rd.addr - r_rd.stride;
                    n_phase = stad_pkg::PH_HEADER;
                    n_state = stad_pkg::B_IDLE;
                end
            end
            stad_pkg::B_SUM: begin
                n_a     = r_base + r_off;
                n_state = stad_pkg::B_FIN;
            end
            stad_pkg::B_FIN: begin
                if (out_free) begin
                    emit              = 1'b1;
                    emit_val.address  = r_a;
                    emit_val.out_slot = r_cslot;
                    emit_val.out_type = r_ctype;
                    emit_val.error    = stad_pkg::ERR_OK;
                    we                = 1'b1;
                    wd.addr           = r_a + r_str;
                    wd.stride         = r_str;
                    wd.rep            = r_rep;
                    n_phase           = stad_pkg::PH_IDLE;
                    n_state           = stad_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = stad_pkg::B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stad_pkg::B_CLEAR;
            r_phase <= stad_pkg::PH_IDLE;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_clr   <= n_clr;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx  <= n_cidx;
        r_cslot <= n_cslot;
        r_ctype <= n_ctype;
        r_hdr   <= n_hdr;
        r_acc   <= n_acc;
        r_off   <= n_off;
        r_str   <= n_str;
        r_rep   <= n_rep;
        r_base  <= n_base;
        r_a     <= n_a;
        r_left  <= n_left;
        if (emit) begin
            r_out <= emit_val;
        end
    end

`ifndef SYNTHESIS
    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.error != stad_pkg::ERR_OK) |-> (r_out.address == 64'd0))
        else $error("error item carries an address");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stad_pkg::B_CLEAR) |-> !o_pop)
        else $error("queue popped during clear");

    a_sum_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stad_pkg::B_SUM) |=> (r_state == stad_pkg::B_FIN))
        else $error("sum not followed by finish");

    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stad_pkg::B_FIN) |-> (r_phase != stad_pkg::PH_IDLE))
        else $error("finish with idle parser");
`endif

endmodule

/* rtl/stride_trace_address_decoder.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in  (stad_pkg::t_in)
// out       output     o_out_valid / i_out_ready   o_out (stad_pkg::t_out)
//
// an item passes the front register and the queue, then the back: a data byte
// is taken in B_IDLE, a request in B_LOOK (registered slot memory read), the
// last byte of a record in B_SUM and B_FIN (address sum and slot write-back)
// after reset a clearing pass writes all SLOT_COUNT slot entries, o_in_ready low
// the output register lets items that emit nothing pass while a result waits

module stride_trace_address_decoder #(
    parameter int SLOT_COUNT  = stad_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = stad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  stad_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output stad_pkg::t_out o_out
);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int QW = IW + $bits(stad_pkg::t_in);

    stad_pkg::t_bstat stat;
    stad_pkg::t_in    f_item, q_item;
    logic [IW-1:0]    f_idx, q_idx;
    logic             push, pop, full, empty;

    stad_front #(.SLOT_COUNT(SLOT_COUNT), .IW(IW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in),
        .i_stat  (stat),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item),
        .o_idx   (f_idx)
    );

    stad_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_idx, f_item}),
        .i_pop   (pop),
        .o_data  ({q_idx, q_item}),
        .o_full  (full),
        .o_empty (empty)
    );

    stad_back #(.SLOT_COUNT(SLOT_COUNT), .IW(IW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (q_item),
        .i_head_idx (q_idx),
        .o_pop      (pop),
        .o_stat     (stat),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out)
    );

endmodule

/* tb/stride_trace_address_decoder_tb.sv */
`timescale 1ns / 1ps

module stride_trace_address_decoder_tb;

    localparam int NSLOT = stad_pkg::SLOT_COUNT_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    stad_pkg::t_in i_in;
    logic o_out_valid;
    logic i_out_ready;
    stad_pkg::t_out o_out;

    stride_trace_address_decoder i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    // decoder state kept by the predictor
    logic [63:0] addr_mem [NSLOT];
    logic [63:0] stride_mem [NSLOT];
    logic [63:0] count_mem [NSLOT];
    stad_pkg::t_phase phase;
    logic [9:0] wait_slot;
    logic [1:0] wait_type;
    logic [7:0] hdr;
    logic [63:0] accum;
    int left;
    logic [63:0] offs_hold;
    logic [63:0] strd_hold;

    stad_pkg::t_in pending_items[$];
    stad_pkg::t_out expected_addrs[$];
    int mismatches;
    int sent_count;
    longint cycles;
    bit stim_done;
    bit hold_off_req;
    int hold_off_left;
    bit drain_req;

    function automatic int nbytes(input logic [1:0] code);
        case (code)
            2'd0: return 1;
            2'd1: return 2;
            2'd2: return 4;
            default: return 8;
        endcase
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = v;
        if (n < 8) begin
            for (int i = 8 * n; i < 64; i++) r[i] = v[8 * n - 1];
        end
        return r;
    endfunction

    function automatic stad_pkg::t_out mk(input logic [63:0] a, input logic [9:0] s,
                                          input logic [1:0] t, input stad_pkg::t_err e);
        stad_pkg::t_out o;
        o.address = a;
        o.out_slot = s;
        o.out_type = t;
        o.error = e;
        return o;
    endfunction

    task automatic finish_decode(input logic [63:0] rep);
        logic [63:0] a;
        int s;
        s = wait_slot % NSLOT;
        a = addr_mem[s] - stride_mem[s] + offs_hold;
        expected_addrs.push_back(mk(addr_mem[s] - stride_mem[s] + offs_hold, wait_slot,
                                    wait_type, stad_pkg::ERR_OK));
        addr_mem[s] = a + strd_hold;
        stride_mem[s] = strd_hold;
        count_mem[s] = rep;
        // the waiting request is answered now; the new slot state serves only later requests
        phase = stad_pkg::PH_IDLE;
    endtask

    task automatic enter_rep;
        logic [2:0] c;
        c = hdr[7:5];
        if (c == 3'd0) finish_decode(64'd0);
        else if (c == 3'd5) finish_decode(64'd1);
        else begin
            phase = stad_pkg::PH_REPEAT;
            left = nbytes(2'(c - 3'd1));
            accum = '0;
        end
    endtask

    task automatic enter_strd;
        logic [2:0] c;
        c = hdr[4:2];
        case (c)
            3'd0: begin strd_hold = 64'd0; enter_rep(); end
            3'd5: begin strd_hold = 64'd1; enter_rep(); end
            3'd6: begin strd_hold = 64'd4; enter_rep(); end
            3'd7: begin strd_hold = 64'd8; enter_rep(); end
            default: begin
                phase = stad_pkg::PH_STRIDE;
                left = nbytes(2'(c - 3'd1));
                accum = '0;
            end
        endcase
    endtask

    task automatic predict_decode(input stad_pkg::t_in it);
        int s;
        int total;
        int idx;
        logic [63:0] v;
        s = it.slot % NSLOT;
        if (it.kind == stad_pkg::KIND_REQ) begin
            if (phase != stad_pkg::PH_IDLE) begin
                expected_addrs.push_back(mk(64'd0, it.slot, it.access_type,
                                            stad_pkg::ERR_ORDER));
            end else if (count_mem[s] != 64'd0) begin
                expected_addrs.push_back(mk(addr_mem[s], it.slot, it.access_type,
                                            stad_pkg::ERR_OK));
                addr_mem[s] += stride_mem[s];
                count_mem[s] -= 64'd1;
            end else begin
                wait_slot = it.slot;
                wait_type = it.access_type;
                phase = stad_pkg::PH_HEADER;
            end
        end else if (phase == stad_pkg::PH_IDLE) begin
            expected_addrs.push_back(mk(64'd0, 10'd0, 2'd0, stad_pkg::ERR_ORDER));
        end else if (phase == stad_pkg::PH_HEADER) begin
            hdr = it.data_byte;
            if (it.data_byte[7:6] == 2'b11) begin
                phase = stad_pkg::PH_IDLE;
                expected_addrs.push_back(mk(64'd0, wait_slot, wait_type,
                                            stad_pkg::ERR_REPEAT));
            end else begin
                phase = stad_pkg::PH_OFFSET;
                left = nbytes(it.data_byte[1:0]);
                accum = '0;
            end
        end else begin
            if (phase == stad_pkg::PH_OFFSET) total = nbytes(hdr[1:0]);
            else if (phase == stad_pkg::PH_STRIDE) total = nbytes(2'(hdr[4:2] - 3'd1));
            else total = nbytes(2'(hdr[7:5] - 3'd1));
            idx = total - left;
            accum |= 64'(it.data_byte) << (8 * idx);
            left--;
            if (left == 0) begin
                v = sext(accum, total);
                if (phase == stad_pkg::PH_OFFSET) begin
                    offs_hold = v;
                    enter_strd();
                end else if (phase == stad_pkg::PH_STRIDE) begin
                    strd_hold = v;
                    enter_rep();
                end else finish_decode(v);
            end
        end
    endtask

    // stimulus builders
    function automatic stad_pkg::t_in req(input logic [9:0] s, input logic [1:0] t);
        stad_pkg::t_in it;
        it = '0;
        it.kind = stad_pkg::KIND_REQ;
        it.slot = s;
        it.access_type = t;
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    function automatic stad_pkg::t_in dbyte(input logic [7:0] b);
        stad_pkg::t_in it;
        it.kind = stad_pkg::KIND_BYTE;
        it.slot = 10'($urandom);
        it.access_type = 2'($urandom);
        it.data_byte = b;
        return it;
    endfunction

    task automatic push_field(input int n, input bit extreme);
        for (int i = 0; i < n; i++) begin
            if (extreme) pending_items.push_back(dbyte(8'hff));
            else pending_items.push_back(dbyte(8'($urandom)));
        end
    endtask

    // a request followed by its header and fields; repeat counts are always small
    task automatic push_record(input logic [9:0] s, input logic [7:0] h);
        pending_items.push_back(req(s, 2'($urandom)));
        pending_items.push_back(dbyte(h));
        if (h[7:6] == 2'b11) return;
        push_field(nbytes(h[1:0]), 1'b0);
        if (h[4:2] inside {[3'd1:3'd4]}) push_field(nbytes(2'(h[4:2] - 3'd1)), 1'b0);
        if (h[7:5] inside {[3'd1:3'd4]}) begin
            pending_items.push_back(dbyte(8'($urandom_range(0, 5))));
            for (int i = 1; i < nbytes(2'(h[7:5] - 3'd1)); i++) begin
                pending_items.push_back(dbyte(8'h00));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        logic [9:0] s;
        i_rst_n = 1'b0;
        foreach (addr_mem[k]) begin
            addr_mem[k] = '0;
            stride_mem[k] = '0;
            count_mem[k] = '0;
        end
        phase = stad_pkg::PH_IDLE;
        wait_slot = '0;
        wait_type = '0;
        hdr = '0;
        accum = '0;
        left = 0;
        offs_hold = '0;
        strd_hold = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: order errors, bad repeat codes, one- and two-byte offsets, extreme slots
        pending_items.push_back(dbyte(8'h5a));
        push_record(10'd0, 8'hc0);
        push_record(10'd1023, 8'he3);
        pending_items.push_back(req(10'd5, 2'd3));
        pending_items.push_back(req(10'd6, 2'd1));
        pending_items.push_back(dbyte(8'h00));
        pending_items.push_back(req(10'd1023, 2'd2));
        pending_items.push_back(dbyte(8'hbf));
        push_field(8, 1'b1);
        push_field(2, 1'b0);
        pending_items.push_back(dbyte(8'h07));
        pending_items.push_back(req(10'd1023, 2'd0));
        pending_items.push_back(req(10'd1023, 2'd1));
        pending_items.push_back(req(10'd1023, 2'd2));
        pending_items.push_back(req(10'd0, 2'd0));
        pending_items.push_back(dbyte(8'b101_10101));
        pending_items.push_back(dbyte(8'h80));
        pending_items.push_back(dbyte(8'h00));
        pending_items.push_back(dbyte(8'h80));

        while (pending_items.size() < 950) begin
            s = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0: pending_items.push_back(dbyte(8'($urandom)));
                1, 2, 3: pending_items.push_back(req(s, 2'($urandom)));
                4: begin
                    pending_items.push_back(req(s, 2'($urandom)));
                    pending_items.push_back(dbyte(8'($urandom)));
                end
                default: push_record(s, 8'($urandom));
            endcase
            if ($urandom_range(0, 200) == 0) push_record(s, 8'hbf);
        end
        // let the queue settle before starting the long receiver hold-off
        wait (sent_count > 300);
        hold_off_left = 300;
        hold_off_req = 1'b1;
        wait (sent_count > 600);
        drain_req = 1'b1;
        wait (expected_addrs.size() == 0);
        drain_req = 1'b0;
        wait (stim_done);
        wait (expected_addrs.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("PASS stride_trace_address_decoder");
        else $display("FAIL stride_trace_address_decoder");
        $finish;
    end

    // driver
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in <= '0;
            burst_left <= 0;
            gap_left <= 0;
            sent_count <= 0;
            stim_done <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_decode(i_in);
                sent_count <= sent_count + 1;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the item
            end else if (gap_left > 0 || drain_req || pending_items.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
                if (pending_items.size() == 0 && !(i_in_valid && !o_in_ready)) begin
                    stim_done <= 1'b1;
                end
            end else begin
                i_in <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else burst_left <= burst_left - 1;
            end
        end
    end

    // receiver with its own stall pattern and a long hold-off
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_phase <= 0;
        end else if (hold_off_req && hold_off_left > 0) begin
            i_out_ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else begin
            stall_phase <= stall_phase + 1;
            i_out_ready <= (stall_phase % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        stad_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_addrs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out);
            end else begin
                want = expected_addrs.pop_front();
                if (want !== o_out) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, o_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL stride_trace_address_decoder");
            $finish;
        end
    end

    initial begin
        cycles = 0;
        mismatches = 0;
        hold_off_req = 1'b0;
        hold_off_left = 0;
        drain_req = 1'b0;
    end

endmodule
